[src/cdap_pkg.sv]
// ----------------------------------------------------------------------------
// Compact dipole acoustic pressure package
// Shared constants, register indexes, divider control and output saturation.
// ----------------------------------------------------------------------------
package cdap_pkg;

  localparam int QW = 128;
  localparam int DW = 68;
  localparam int CFG_IDX_W = 3;

  localparam logic [31:0] FOUR_PI_Q28 = 32'd3373259426;
  localparam logic [30:0] SOUND_SPEED_RST = 31'd22478848;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTRE_X       = 3'd0,
    REG_CENTRE_Y       = 3'd1,
    REG_CENTRE_Z       = 3'd2,
    REG_SOUND_SPEED    = 3'd3,
    REG_REF_DISTANCE   = 3'd4,
    REG_OBSERVER_COUNT = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic       start;
    logic [5:0] shift;
  } div_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [QW-1:0] v);
    logic signed [31:0] res;
    if (v[QW-1:31] == {(QW-31){v[QW-1]}}) begin
      res = v[31:0];
    end else if (v[QW-1]) begin
      res = 32'sh8000_0000;
    end else begin
      res = 32'sh7FFF_FFFF;
    end
    return res;
  endfunction

endpackage

[src/cdap_div.sv]
// ----------------------------------------------------------------------------
// Compact dipole acoustic pressure divider
// Restoring divider, one quotient bit per cycle, giving trunc(num*2^k/den)
// toward zero with the magnitude saturated just below 2^127.
// ----------------------------------------------------------------------------
module cdap_div (
  input  logic                            clk,
  input  logic                            rst,
  input  cdap_pkg::div_ctl_t              ctl,
  input  logic signed [cdap_pkg::QW-1:0]  num,
  input  logic        [cdap_pkg::DW-1:0]  den,
  output logic                            done,
  output logic signed [cdap_pkg::QW-1:0]  quot
);
  import cdap_pkg::*;

  logic          busy;
  logic          neg;
  logic [QW-1:0] mag;
  logic [QW-1:0] q;
  logic [DW-1:0] rem;
  logic [DW:0]   trial;
  logic [7:0]    cnt;
  logic [7:0]    total;
  logic          sat;

  assign trial = {rem, mag[QW-1]};
  assign sat   = q[QW-1] | q[QW-2];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (ctl.start) begin
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy && (sat || cnt == total - 8'd1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mag   <= num[QW-1] ? QW'(-num) : QW'(num);
      neg   <= num[QW-1];
      q     <= '0;
      rem   <= '0;
      cnt   <= '0;
      total <= 8'(QW) + 8'(ctl.shift);
    end else if (busy) begin
      if (sat) begin
        q <= {1'b0, {(QW-1){1'b1}}};
      end else begin
        mag <= {mag[QW-2:0], 1'b0};
        cnt <= cnt + 8'd1;
        if (trial >= {1'b0, den}) begin
          rem <= DW'(trial - {1'b0, den});
          q   <= {q[QW-2:0], 1'b1};
        end else begin
          rem <= trial[DW-1:0];
          q   <= {q[QW-2:0], 1'b0};
        end
      end
    end
  end

  assign quot = neg ? -signed'(q) : signed'(q);

endmodule

[src/compact_dipole_acoustic_pressure.sv]
// ----------------------------------------------------------------------------
// Compact dipole acoustic pressure
// Far-field compact-source dipole pressure for a set of stored observers.
// ----------------------------------------------------------------------------
// An input beat with func 0 stores one observer position (a slot at or above
// the memory depth is ignored). A beat with func 1 supplies a force sample and
// yields one result beat per observer. All quotients share one bit-serial
// divider: a sample first divides for the force derivative and then forms the
// constant product (only the constant product on the very first sample), and
// then each observer runs its divisions, with one fewer when the reference
// distance is zero and none for an observer at the centroid. New beats are
// stalled until every observer is done. Positions live in a registered-read memory.
// ----------------------------------------------------------------------------
module compact_dipole_acoustic_pressure #(
  parameter int MAX_OBSERVERS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cdap_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 func,
  input  logic [3:0]                           obs_index,
  input  logic signed [31:0]                   pos_x,
  input  logic signed [31:0]                   pos_y,
  input  logic signed [31:0]                   pos_z,
  input  logic signed [31:0]                   force_x,
  input  logic signed [31:0]                   force_y,
  input  logic signed [31:0]                   force_z,
  input  logic [31:0]                          time_step,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [3:0]                           observer_slot,
  output logic signed [31:0]                   pressure,
  output logic                                 zero_distance,
  output logic                                 last
);
  import cdap_pkg::*;

  localparam int DEPTH = (MAX_OBSERVERS < 16) ? MAX_OBSERVERS : 16;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DFW   = 68;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_DIV_GO   = 10'b00_0000_0010,
    S_DIV_WAIT = 10'b00_0000_0100,
    S_MUL_GO   = 10'b00_0000_1000,
    S_MUL_WAIT = 10'b00_0001_0000,
    S_RD       = 10'b00_0010_0000,
    S_LOAD     = 10'b00_0100_0000,
    S_CHECK    = 10'b00_1000_0000,
    S_SQRT     = 10'b01_0000_0000,
    S_EMIT     = 10'b10_0000_0000
  } state_t;

  typedef enum logic [2:0] {D_DF, D_Q1, D_S, D_K, D_REF} dop_t;
  typedef enum logic [2:0] {M_KC, M_R2, M_D, M_E, M_EC} mop_t;

  state_t state;
  dop_t   dop;
  mop_t   mop;

  logic signed [31:0]    centre [3];
  logic [30:0]           sound_speed_r;
  logic [30:0]           ref_dist;
  logic [4:0]            obs_count;
  logic [30:0]           c0;
  logic [4:0]            n_obs;

  logic signed [31:0]    fin [3];
  logic signed [31:0]    prev_f [3];
  logic signed [31:0]    older_f [3];
  logic [1:0]            hist_len;
  logic signed [35:0]    dnum_in [3];
  logic signed [35:0]    dnum [3];
  logic                  df_first;
  logic [31:0]           t_step;
  logic signed [DFW-1:0] dfdt [3];

  logic signed [32:0]    lv [3];
  logic [DW-1:0]         r2;
  logic signed [QW-1:0]  dacc;
  logic signed [QW-1:0]  eacc;
  logic signed [QW-1:0]  ec;
  logic signed [QW-1:0]  sval;
  logic signed [QW-1:0]  pr;
  logic [63:0]           kc0;
  logic [33:0]           root;
  logic [35:0]           sq_rem;
  logic [DW-1:0]         sq_rad;
  logic [5:0]            sq_step;
  logic [37:0]           sq_t;
  logic [37:0]           sq_trial;
  logic [4:0]            obs_i;
  logic [1:0]            ax;
  logic                  zd;

  logic [95:0]           obs_mem [DEPTH];
  logic [95:0]           rd_data;

  logic                  mul_start;
  logic                  mul_busy;
  logic                  mul_done;
  logic                  mul_neg;
  logic [1:0]            mul_cnt;
  logic [QW-1:0]         mul_a;
  logic [QW-1:0]         mul_acc;
  logic [32:0]           mul_b;
  logic [64:0]           mul_part;
  logic signed [QW-1:0]  mul_opa;
  logic signed [33:0]    mul_opb;
  logic signed [QW-1:0]  mul_prod;

  div_ctl_t              div_ctl;
  logic signed [QW-1:0]  div_num;
  logic [DW-1:0]         div_den;
  logic                  div_done;
  logic signed [QW-1:0]  div_quot;

  logic                  in_take;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign c0        = (sound_speed_r == '0) ? 31'd1 : sound_speed_r;
  assign n_obs     = (obs_count > 5'(DEPTH)) ? 5'(DEPTH) : obs_count;

  assign fin[0] = force_x;
  assign fin[1] = force_y;
  assign fin[2] = force_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (hist_len == 2'd1) begin
        dnum_in[k] = 36'(fin[k]) - 36'(prev_f[k]);
      end else begin
        dnum_in[k] = 36'(fin[k]) + (36'(fin[k]) <<< 1) - (36'(prev_f[k]) <<< 2)
                     + 36'(older_f[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && !func && ({1'b0, obs_index} < 5'(DEPTH))) begin
      obs_mem[obs_index[AW-1:0]] <= {pos_z, pos_y, pos_x};
    end
    rd_data <= obs_mem[obs_i[AW-1:0]];
  end

  always_comb begin
    case (mop)
      M_KC: begin
        mul_opa = QW'(signed'({1'b0, FOUR_PI_Q28}));
        mul_opb = 34'(signed'({1'b0, c0}));
      end
      M_R2: begin
        mul_opa = QW'(lv[ax]);
        mul_opb = 34'(lv[ax]);
      end
      M_D: begin
        mul_opa = QW'(dfdt[ax]);
        mul_opb = 34'(lv[ax]);
      end
      M_E: begin
        mul_opa = QW'(prev_f[ax]);
        mul_opb = 34'(lv[ax]);
      end
      M_EC: begin
        mul_opa = eacc;
        mul_opb = 34'(signed'({1'b0, c0}));
      end
      default: begin
        mul_opa = '0;
        mul_opb = '0;
      end
    endcase
  end

  assign mul_start = (state == S_MUL_GO);
  assign mul_part  = mul_a[QW-1:QW-32] * mul_b;
  assign mul_prod  = mul_neg ? -signed'(mul_acc) : signed'(mul_acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
      mul_done <= 1'b0;
    end else begin
      if (mul_start) begin
        mul_busy <= 1'b1;
        mul_done <= 1'b0;
      end else if (mul_busy && mul_cnt == 2'd3) begin
        mul_busy <= 1'b0;
        mul_done <= 1'b1;
      end else begin
        mul_done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_start) begin
      mul_a   <= mul_opa[QW-1] ? QW'(-mul_opa) : QW'(mul_opa);
      mul_b   <= mul_opb[33] ? 33'(-mul_opb) : 33'(mul_opb);
      mul_neg <= mul_opa[QW-1] ^ mul_opb[33];
      mul_acc <= '0;
      mul_cnt <= '0;
    end else if (mul_busy) begin
      mul_acc <= (mul_acc << 32) + QW'(mul_part);
      mul_a   <= mul_a << 32;
      mul_cnt <= mul_cnt + 2'd1;
    end
  end

  always_comb begin
    div_ctl.start = (state == S_DIV_GO);
    case (dop)
      D_DF: begin
        div_num       = QW'(dnum[ax]);
        div_den       = DW'(t_step);
        div_ctl.shift = df_first ? 6'd32 : 6'd31;
      end
      D_Q1: begin
        div_num       = ec;
        div_den       = DW'(root);
        div_ctl.shift = 6'd0;
      end
      D_S: begin
        div_num       = sval;
        div_den       = r2;
        div_ctl.shift = 6'd32;
      end
      D_K: begin
        div_num       = pr;
        div_den       = DW'(kc0);
        div_ctl.shift = 6'd28;
      end
      D_REF: begin
        div_num       = pr;
        div_den       = DW'(ref_dist);
        div_ctl.shift = 6'd16;
      end
      default: begin
        div_num       = '0;
        div_den       = '0;
        div_ctl.shift = '0;
      end
    endcase
  end

  cdap_div u_div (
    .clk  (clk),
    .rst  (rst),
    .ctl  (div_ctl),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_quot)
  );

  assign sq_t     = {sq_rem, sq_rad[DW-1:DW-2]};
  assign sq_trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      hist_len      <= '0;
      centre[0]     <= '0;
      centre[1]     <= '0;
      centre[2]     <= '0;
      sound_speed_r <= SOUND_SPEED_RST;
      ref_dist      <= '0;
      obs_count     <= 5'd1;
      for (int k = 0; k < 3; k++) begin
        prev_f[k]  <= '0;
        older_f[k] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_CENTRE_X:       centre[0] <= cfg_data;
          REG_CENTRE_Y:       centre[1] <= cfg_data;
          REG_CENTRE_Z:       centre[2] <= cfg_data;
          REG_SOUND_SPEED:    sound_speed_r <= cfg_data[30:0];
          REG_REF_DISTANCE:   ref_dist <= cfg_data[30:0];
          REG_OBSERVER_COUNT: obs_count <= cfg_data[4:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_take && func) begin
            df_first <= (hist_len == 2'd1);
            t_step   <= (time_step == '0) ? 32'd1 : time_step;
            for (int k = 0; k < 3; k++) begin
              dnum[k]   <= dnum_in[k];
              prev_f[k] <= fin[k];
              if (hist_len != 2'd0) begin
                older_f[k] <= prev_f[k];
              end
              if (hist_len == 2'd0) begin
                dfdt[k] <= '0;
              end
            end
            if (hist_len != 2'd2) begin
              hist_len <= hist_len + 2'd1;
            end
            ax <= 2'd0;
            if (n_obs != 5'd0) begin
              if (hist_len == 2'd0) begin
                mop   <= M_KC;
                state <= S_MUL_GO;
              end else begin
                dop   <= D_DF;
                state <= S_DIV_GO;
              end
            end
          end
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            case (dop)
              D_DF: begin
                dfdt[ax] <= div_quot[DFW-1:0];
                if (ax == 2'd2) begin
                  mop   <= M_KC;
                  state <= S_MUL_GO;
                end else begin
                  ax    <= ax + 2'd1;
                  state <= S_DIV_GO;
                end
              end
              D_Q1: begin
                sval  <= dacc + div_quot;
                dop   <= D_S;
                state <= S_DIV_GO;
              end
              D_S: begin
                pr    <= div_quot;
                dop   <= D_K;
                state <= S_DIV_GO;
              end
              D_K: begin
                pr <= div_quot;
                if (ref_dist != '0) begin
                  dop   <= D_REF;
                  state <= S_DIV_GO;
                end else begin
                  state <= S_EMIT;
                end
              end
              default: begin
                pr    <= div_quot;
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_MUL_GO: begin
          state <= S_MUL_WAIT;
        end
        S_MUL_WAIT: begin
          if (mul_done) begin
            case (mop)
              M_KC: begin
                kc0   <= mul_prod[63:0];
                obs_i <= '0;
                state <= S_RD;
              end
              M_R2: begin
                r2    <= r2 + mul_prod[DW-1:0];
                mop   <= M_D;
                state <= S_MUL_GO;
              end
              M_D: begin
                dacc  <= dacc + mul_prod;
                mop   <= M_E;
                state <= S_MUL_GO;
              end
              M_E: begin
                eacc <= eacc + mul_prod;
                if (ax == 2'd2) begin
                  state <= S_CHECK;
                end else begin
                  ax    <= ax + 2'd1;
                  mop   <= M_R2;
                  state <= S_MUL_GO;
                end
              end
              default: begin
                ec    <= mul_prod;
                dop   <= D_Q1;
                state <= S_DIV_GO;
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          lv[0] <= 33'(signed'(rd_data[31:0])) - 33'(centre[0]);
          lv[1] <= 33'(signed'(rd_data[63:32])) - 33'(centre[1]);
          lv[2] <= 33'(signed'(rd_data[95:64])) - 33'(centre[2]);
          r2    <= '0;
          dacc  <= '0;
          eacc  <= '0;
          ax    <= 2'd0;
          mop   <= M_R2;
          state <= S_MUL_GO;
        end
        S_CHECK: begin
          sq_rad  <= r2;
          sq_rem  <= '0;
          root    <= '0;
          sq_step <= '0;
          if (r2 == '0) begin
            zd    <= 1'b1;
            state <= S_EMIT;
          end else begin
            zd    <= 1'b0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          sq_rad  <= sq_rad << 2;
          sq_step <= sq_step + 6'd1;
          if (sq_t >= sq_trial) begin
            sq_rem <= 36'(sq_t - sq_trial);
            root   <= {root[32:0], 1'b1};
          end else begin
            sq_rem <= sq_t[35:0];
            root   <= {root[32:0], 1'b0};
          end
          if (sq_step == 6'd33) begin
            mop   <= M_EC;
            state <= S_MUL_GO;
          end
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            observer_slot <= obs_i[3:0];
            pressure      <= zd ? 32'sd0 : sat32(pr);
            zero_distance <= zd;
            last          <= (5'(obs_i + 5'd1) == n_obs);
            obs_i         <= obs_i + 5'd1;
            if (5'(obs_i + 5'd1) == n_obs) begin
              state <= S_IDLE;
            end else begin
              state <= S_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
